### rtl/sci_pkg.sv
// Shared types and constants of the separable image convolver.
`default_nettype none
package sci_pkg;
	localparam int DEF_MAX_TAPS    = 71;
	localparam int DEF_MAX_COLUMNS = 1024;
	localparam int DEF_MAX_ROWS    = 1024;

	localparam int PIX_W   = 8;
	localparam int TAP_W   = 18;
	localparam int VAL_W   = 20;
	localparam int COORD_W = 10;
	localparam int IDX_W   = 7;
	localparam int CFG_W   = 11;
	localparam int KW_W    = 7;

	localparam int Q_MAX = 524287;
	localparam int Q_MIN = -524288;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HORIZ_WIDTH  = 2'd2;
	localparam logic [1:0] REG_VERT_WIDTH   = 2'd3;

	typedef enum logic [1:0] {
		MODE_HTAP  = 2'd0,
		MODE_VTAP  = 2'd1,
		MODE_PIXEL = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HLOAD,
		ST_HRUN,
		ST_HDRAIN,
		ST_HWRITE,
		ST_VLOAD,
		ST_VRUN,
		ST_VDRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                    en;
		logic [IDX_W-1:0]        idx;
		logic signed [TAP_W-1:0] value;
	} tap_wr_t;

	typedef struct packed {
		logic load;
		logic issue;
	} rd_ctl_t;
endpackage
`default_nettype wire

### rtl/sci_mac.sv
// Registered multiply-accumulate unit, instantiated once in each filter pass.
`default_nettype none
module sci_mac #(
	parameter int A_W   = 9,
	parameter int B_W   = 18,
	parameter int ACC_W = 34
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    in_valid,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [B_W-1:0]   b,
	output logic signed [ACC_W-1:0] acc
);
	logic signed [A_W+B_W-1:0] prod_s1;
	logic                      pv_s1;
	logic signed [ACC_W-1:0]   acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			pv_s1 <= in_valid;
			if (clear) begin
				acc_q <= '0;
			end else if (pv_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

### rtl/sci_hrow.sv
// Horizontal pass: pixel window memory, horizontal tap memory and its accumulator.
`default_nettype none
module sci_hrow #(
	parameter int MAX_TAPS = sci_pkg::DEF_MAX_TAPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sci_pkg::tap_wr_t                 tap_wr,
	input  logic                             pix_we,
	input  logic [sci_pkg::PIX_W-1:0]        pix,
	input  sci_pkg::rd_ctl_t                 ctl,
	input  logic [$clog2(MAX_TAPS)-1:0]      span,
	output logic signed [sci_pkg::VAL_W-1:0] hval
);
	import sci_pkg::*;

	localparam int TW    = $clog2(MAX_TAPS);
	localparam int ACC_W = PIX_W + 1 + TAP_W + TW;

	logic [PIX_W-1:0]        win_mem [MAX_TAPS];
	logic signed [TAP_W-1:0] tap_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]     tap_vld_q;
	logic [TW-1:0]           last_q, last_nxt, rd_q, k_q;
	logic [PIX_W-1:0]        pix_s1;
	logic signed [TAP_W-1:0] tap_s1;
	logic                    tvld_s1, iss_s1;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W:0]   rnd;
	logic signed [ACC_W-8:0] sh;
	logic                    tap_ok;

	assign last_nxt = (last_q == TW'(MAX_TAPS - 1)) ? '0 : last_q + 1'b1;
	assign tap_ok   = tap_wr.en && (32'(tap_wr.idx) < MAX_TAPS);

	always_ff @(posedge clk) begin
		if (pix_we) begin
			win_mem[last_nxt] <= pix;
		end
		if (tap_ok) begin
			tap_mem[tap_wr.idx[TW-1:0]] <= tap_wr.value;
		end
		if (ctl.issue) begin
			pix_s1 <= win_mem[rd_q];
			tap_s1 <= tap_mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= TW'(MAX_TAPS - 1);
			tap_vld_q <= '0;
			rd_q      <= '0;
			k_q       <= '0;
			tvld_s1   <= 1'b0;
			iss_s1    <= 1'b0;
		end else begin
			iss_s1 <= ctl.issue;
			if (pix_we) begin
				last_q <= last_nxt;
			end
			if (tap_ok) begin
				tap_vld_q[tap_wr.idx[TW-1:0]] <= 1'b1;
			end
			if (ctl.load) begin
				// oldest pixel of the kernel span
				rd_q <= (last_q >= span) ? last_q - span : last_q + TW'(MAX_TAPS) - span;
				k_q  <= '0;
			end else if (ctl.issue) begin
				rd_q    <= (rd_q == TW'(MAX_TAPS - 1)) ? '0 : rd_q + 1'b1;
				k_q     <= k_q + 1'b1;
				tvld_s1 <= tap_vld_q[k_q];
			end
		end
	end

	sci_mac #(
		.A_W  (PIX_W + 1),
		.B_W  (TAP_W),
		.ACC_W(ACC_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (ctl.load),
		.in_valid(iss_s1),
		.a       (signed'({1'b0, pix_s1})),
		.b       (tvld_s1 ? tap_s1 : '0),
		.acc     (acc)
	);

	// round half up to Q.8, then saturate
	always_comb begin
		rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(128);
		sh  = rnd[ACC_W:8];
		if (sh > $signed((ACC_W-7)'(Q_MAX))) begin
			hval = VAL_W'(Q_MAX);
		end else if (sh < $signed((ACC_W-7)'(Q_MIN))) begin
			hval = VAL_W'(Q_MIN);
		end else begin
			hval = sh[VAL_W-1:0];
		end
	end
endmodule
`default_nettype wire

### rtl/sci_vcol.sv
// Vertical pass: row store memory, vertical tap memory and its accumulator.
`default_nettype none
module sci_vcol #(
	parameter int MAX_TAPS    = sci_pkg::DEF_MAX_TAPS,
	parameter int MAX_COLUMNS = sci_pkg::DEF_MAX_COLUMNS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sci_pkg::tap_wr_t                    tap_wr,
	input  logic                                row_we,
	input  logic signed [sci_pkg::VAL_W-1:0]    row_val,
	input  logic [$clog2(MAX_TAPS)-1:0]         slot,
	input  logic [$clog2(MAX_COLUMNS)-1:0]      col,
	input  sci_pkg::rd_ctl_t                    ctl,
	input  logic [$clog2(MAX_TAPS)-1:0]         span,
	output logic signed [sci_pkg::VAL_W-1:0]    vval
);
	import sci_pkg::*;

	localparam int TW    = $clog2(MAX_TAPS);
	localparam int AW    = $clog2(MAX_TAPS * MAX_COLUMNS);
	localparam int ACC_W = VAL_W + TAP_W + TW;

	logic signed [VAL_W-1:0] row_mem [MAX_TAPS * MAX_COLUMNS];
	logic signed [TAP_W-1:0] tap_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]     tap_vld_q;
	logic [TW-1:0]           rslot_q, k_q;
	logic [AW-1:0]           wa, ra;
	logic signed [VAL_W-1:0] row_s1;
	logic signed [TAP_W-1:0] tap_s1;
	logic                    tvld_s1, iss_s1;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W:0]   rnd;
	logic signed [ACC_W-16:0] sh;
	logic                    tap_ok;

	assign wa     = AW'(slot) * AW'(MAX_COLUMNS) + AW'(col);
	assign ra     = AW'(rslot_q) * AW'(MAX_COLUMNS) + AW'(col);
	assign tap_ok = tap_wr.en && (32'(tap_wr.idx) < MAX_TAPS);

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[wa] <= row_val;
		end
		if (tap_ok) begin
			tap_mem[tap_wr.idx[TW-1:0]] <= tap_wr.value;
		end
		if (ctl.issue) begin
			row_s1 <= row_mem[ra];
			tap_s1 <= tap_mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_q <= '0;
			rslot_q   <= '0;
			k_q       <= '0;
			tvld_s1   <= 1'b0;
			iss_s1    <= 1'b0;
		end else begin
			iss_s1 <= ctl.issue;
			if (tap_ok) begin
				tap_vld_q[tap_wr.idx[TW-1:0]] <= 1'b1;
			end
			if (ctl.load) begin
				// topmost row of the kernel, ring order in the store
				rslot_q <= (slot >= span) ? slot - span : slot + TW'(MAX_TAPS) - span;
				k_q     <= '0;
			end else if (ctl.issue) begin
				rslot_q <= (rslot_q == TW'(MAX_TAPS - 1)) ? '0 : rslot_q + 1'b1;
				k_q     <= k_q + 1'b1;
				tvld_s1 <= tap_vld_q[k_q];
			end
		end
	end

	sci_mac #(
		.A_W  (VAL_W),
		.B_W  (TAP_W),
		.ACC_W(ACC_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (ctl.load),
		.in_valid(iss_s1),
		.a       (row_s1),
		.b       (tvld_s1 ? tap_s1 : '0),
		.acc     (acc)
	);

	always_comb begin
		rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(32768);
		sh  = rnd[ACC_W:16];
		if (sh > $signed((ACC_W-15)'(Q_MAX))) begin
			vval = VAL_W'(Q_MAX);
		end else if (sh < $signed((ACC_W-15)'(Q_MIN))) begin
			vval = VAL_W'(Q_MIN);
		end else begin
			vval = sh[VAL_W-1:0];
		end
	end
endmodule
`default_nettype wire

### rtl/separable_image_convolver.sv
// Top level: stream ports, configuration, raster counters and pass sequencer.
// Tap load, unused mode, or pixel outside the filtered columns: taken without leaving idle.
// Pixel with a horizontal result only: HLOAD, HRUN, HDRAIN, HWRITE; with an emitted pixel also
// VLOAD, VRUN, VDRAIN, EMIT; one row store / tap memory read per vertical and horizontal tap.
// One item at a time; a finished result waits in the output register.
// Async reset clears control, tap valid bits, counters and registers (1024, 1024, 7, 7).
`default_nettype none
module separable_image_convolver #(
	parameter int MAX_TAPS    = sci_pkg::DEF_MAX_TAPS,
	parameter int MAX_COLUMNS = sci_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = sci_pkg::DEF_MAX_ROWS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [39:0]               s_tdata,   // tap_index, tap_value, pixel_value, pad
	input  logic [1:0]                s_tuser,   // mode
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [39:0]               m_tdata,   // out_row, out_col, out_value
	output logic                      m_tlast,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [sci_pkg::CFG_W-1:0] cfg_data
);
	import sci_pkg::*;

	localparam int TW   = $clog2(MAX_TAPS);
	localparam int CW   = $clog2(MAX_COLUMNS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int RCAP = (MAX_TAPS - 1) / 2;

	state_t state_q, state_nxt;

	logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
	logic [KW_W-1:0]  cfg_hw_q, cfg_vw_q;
	logic [CW:0]      w_eff;
	logic [RW:0]      h_eff;
	logic [TW-1:0]    hspan, vspan;

	logic [CW-1:0] col_q, cur_c_q, ch;
	logic [RW-1:0] row_q, cur_r_q, orow;
	logic [TW-1:0] slot_q, cur_slot_q;
	logic          vdo_q, end_q;
	logic [TW-1:0] kc_q;
	logic          drain_q;

	logic          accept, pix_acc, hdo, last_col, last_row;
	mode_t         mode;
	tap_wr_t       htap_wr, vtap_wr;
	rd_ctl_t       hctl, vctl;
	logic          row_we, out_load;
	logic signed [VAL_W-1:0] hval, vval;

	logic                    m_valid_q, m_last_q;
	logic [COORD_W-1:0]      orow_q, ocol_q;
	logic signed [VAL_W-1:0] oval_q;

	// effective sizes and kernel spans
	always_comb begin
		if (cfg_w_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(cfg_w_q) > MAX_COLUMNS) begin
			w_eff = (CW+1)'(MAX_COLUMNS);
		end else begin
			w_eff = (CW+1)'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			h_eff = (RW+1)'(1);
		end else if (32'(cfg_h_q) > MAX_ROWS) begin
			h_eff = (RW+1)'(MAX_ROWS);
		end else begin
			h_eff = (RW+1)'(cfg_h_q);
		end
		hspan = (32'(cfg_hw_q[KW_W-1:1]) > RCAP) ? TW'(2 * RCAP)
			: TW'({cfg_hw_q[KW_W-1:1], 1'b0});
		vspan = (32'(cfg_vw_q[KW_W-1:1]) > RCAP) ? TW'(2 * RCAP)
			: TW'({cfg_vw_q[KW_W-1:1], 1'b0});
	end

	assign mode     = mode_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign pix_acc  = accept && (mode == MODE_PIXEL);
	assign hdo      = 32'(col_q) >= 32'(hspan);
	assign last_col = 32'(col_q) + 1 >= 32'(w_eff);
	assign last_row = 32'(row_q) + 1 >= 32'(h_eff);

	always_comb begin
		htap_wr.en    = accept && (mode == MODE_HTAP);
		htap_wr.idx   = s_tdata[6:0];
		htap_wr.value = s_tdata[24:7];
		vtap_wr.en    = accept && (mode == MODE_VTAP);
		vtap_wr.idx   = s_tdata[6:0];
		vtap_wr.value = s_tdata[24:7];
	end

	assign ch   = cur_c_q - CW'(hspan[TW-1:1]);
	assign orow = cur_r_q - RW'(vspan[TW-1:1]);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (pix_acc && hdo) state_nxt = ST_HLOAD;
			ST_HLOAD:  state_nxt = ST_HRUN;
			ST_HRUN:   if (kc_q == hspan) state_nxt = ST_HDRAIN;
			ST_HDRAIN: if (drain_q) state_nxt = ST_HWRITE;
			ST_HWRITE: state_nxt = vdo_q ? ST_VLOAD : ST_IDLE;
			ST_VLOAD:  state_nxt = ST_VRUN;
			ST_VRUN:   if (kc_q == vspan) state_nxt = ST_VDRAIN;
			ST_VDRAIN: if (drain_q) state_nxt = ST_EMIT;
			ST_EMIT:   if (!m_valid_q || m_tready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		hctl     = '0;
		vctl     = '0;
		row_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_HLOAD:  hctl.load  = 1'b1;
			ST_HRUN:   hctl.issue = 1'b1;
			ST_HWRITE: row_we     = 1'b1;
			ST_VLOAD:  vctl.load  = 1'b1;
			ST_VRUN:   vctl.issue = 1'b1;
			ST_EMIT:   out_load   = !m_valid_q || m_tready;
			default:   hctl       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cfg_w_q    <= CFG_W'(1024);
			cfg_h_q    <= CFG_W'(1024);
			cfg_hw_q   <= KW_W'(7);
			cfg_vw_q   <= KW_W'(7);
			col_q      <= '0;
			row_q      <= '0;
			slot_q     <= '0;
			cur_c_q    <= '0;
			cur_r_q    <= '0;
			cur_slot_q <= '0;
			vdo_q      <= 1'b0;
			end_q      <= 1'b0;
			kc_q       <= '0;
			drain_q    <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  cfg_w_q  <= cfg_data;
					REG_IMAGE_HEIGHT: cfg_h_q  <= cfg_data;
					REG_HORIZ_WIDTH:  cfg_hw_q <= cfg_data[KW_W-1:0];
					REG_VERT_WIDTH:   cfg_vw_q <= cfg_data[KW_W-1:0];
					default:          cfg_w_q  <= cfg_w_q;
				endcase
				col_q  <= '0;
				row_q  <= '0;
				slot_q <= '0;
			end else if (pix_acc) begin
				cur_c_q    <= col_q;
				cur_r_q    <= row_q;
				cur_slot_q <= slot_q;
				vdo_q      <= 32'(row_q) >= 32'(vspan);
				end_q      <= last_col && last_row;
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= row_q + 1'b1;
						slot_q <= (slot_q == TW'(MAX_TAPS - 1)) ? '0 : slot_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (state_q == ST_HLOAD || state_q == ST_VLOAD) begin
				kc_q <= '0;
			end else if (state_q == ST_HRUN || state_q == ST_VRUN) begin
				kc_q <= kc_q + 1'b1;
			end
			drain_q <= (state_q == ST_HDRAIN || state_q == ST_VDRAIN) && !drain_q;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			orow_q   <= COORD_W'(orow);
			ocol_q   <= COORD_W'(ch);
			oval_q   <= vval;
			m_last_q <= end_q;
		end
	end

	sci_hrow #(
		.MAX_TAPS(MAX_TAPS)
	) u_hrow (
		.clk   (clk),
		.arst_n(arst_n),
		.tap_wr(htap_wr),
		.pix_we(pix_acc),
		.pix   (s_tdata[32:25]),
		.ctl   (hctl),
		.span  (hspan),
		.hval  (hval)
	);

	sci_vcol #(
		.MAX_TAPS   (MAX_TAPS),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_vcol (
		.clk    (clk),
		.arst_n (arst_n),
		.tap_wr (vtap_wr),
		.row_we (row_we),
		.row_val(hval),
		.slot   (cur_slot_q),
		.col    (ch),
		.ctl    (vctl),
		.span   (vspan),
		.vval   (vval)
	);

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {oval_q, ocol_q, orow_q};

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(w_eff))
		else $error("column counter beyond image width");
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slot_q) < MAX_TAPS)
		else $error("row slot beyond row store depth");
	a_vert_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_VLOAD |-> $past(state_q) == ST_HWRITE)
		else $error("vertical pass started without a row store write");
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result loaded outside emit");
endmodule
`default_nettype wire
